// ===== sv/mppm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mppm_pkg;

  // command codes of an input word
  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_EDGE      = 3'd1;
  localparam logic [2:0] CMD_RD_COUNT  = 3'd2;
  localparam logic [2:0] CMD_RST_COUNT = 3'd3;
  localparam logic [2:0] CMD_RD_PERIOD = 3'd4;
  localparam logic [2:0] CMD_RD_FREQ   = 3'd5;
  localparam logic [2:0] CMD_RD_AGE    = 3'd6;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEBASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd1;

  localparam logic [15:0] PERIOD_INVALID = 16'hFFFF;

  // frequency = FREQ_SCALE / period, dividend fits in DIV_STEPS bits
  localparam int DIV_STEPS = 14;
  localparam logic [DIV_STEPS-1:0] FREQ_SCALE = 14'd10000;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic div_start;
  } ctl_t;

  typedef struct packed {
    logic has_result;
    logic need_div;
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/mppm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mppm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [3:0] channel;
  modport source (output valid, output cmd, output channel, input ready);
  modport sink (input valid, input cmd, input channel, output ready);
endinterface

interface mppm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        status;
  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

interface mppm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/mppm_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mppm_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [mppm_pkg::DIV_STEPS-1:0] quotient
);
  import mppm_pkg::*;

  logic                 busy;
  logic [3:0]           cnt;
  logic [15:0]          rem;
  logic [15:0]          dvs;
  logic [DIV_STEPS-1:0] q;
  logic [16:0]          rem_sh;
  logic [16:0]          rem_sub;
  logic                 ge;

  // restoring division, one quotient bit a cycle
  assign rem_sh  = {rem, q[DIV_STEPS-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign ge      = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == 4'(DIV_STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'(DIV_STEPS - 1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      q   <= FREQ_SCALE;
    end else if (busy) begin
      rem <= ge ? rem_sub[15:0] : rem_sh[15:0];
      q   <= {q[DIV_STEPS-2:0], ge};
    end
  end

  assign quotient = q;

endmodule

`default_nettype wire

// ===== sv/mppm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mppm_datapath #(
  parameter int CHANNELS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic [mppm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [3:0]  in_channel,
  input  wire mppm_pkg::ctl_t ctl,
  output mppm_pkg::sts_t   sts,
  output logic [31:0]      value,
  output logic             status
);
  import mppm_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [15:0] timebase_ms;
  logic [15:0] channel_enable;
  logic [15:0] time_now;
  logic [31:0] edge_count     [CHANNELS];
  logic [15:0] last_edge_time [CHANNELS];
  logic [15:0] last_period    [CHANNELS];

  logic [2:0]  cmd_r;
  logic [3:0]  ch_r;

  logic [IDX_W-1:0] idx;
  logic        on;
  logic [31:0] cnt_cur;
  logic [15:0] lt_cur;
  logic [15:0] lp_cur;
  logic [15:0] age_raw;
  logic [15:0] age_val;
  logic        stale;
  logic        tb_on;
  logic        in_window;
  logic [15:0] period_rd;
  logic [16:0] sum;
  logic [15:0] divisor;
  logic [DIV_STEPS-1:0] quotient;
  logic        div_done;

  assign idx     = ch_r[IDX_W-1:0];
  assign on      = ({1'b0, ch_r} < 5'(CHANNELS)) && channel_enable[ch_r];
  assign cnt_cur = edge_count[idx];
  assign lt_cur  = last_edge_time[idx];
  assign lp_cur  = last_period[idx];
  assign age_raw = time_now - lt_cur;
  // an invalidated period reads as maximal age
  assign age_val   = (lp_cur == PERIOD_INVALID) ? PERIOD_INVALID : age_raw;
  assign stale     = (lp_cur != PERIOD_INVALID) && (timebase_ms < age_raw);
  assign tb_on     = timebase_ms != 16'd0;
  assign in_window = age_val < timebase_ms;
  assign period_rd = (on && tb_on && in_window) ?
                     ((lp_cur == 16'd0) ? 16'd1 : lp_cur) : PERIOD_INVALID;

  // averaged period when the signal has gone quiet for over two periods
  assign sum     = {1'b0, lp_cur} + {1'b0, age_val};
  assign divisor = ({lp_cur, 1'b0} < {1'b0, age_val}) ? sum[16:1] : lp_cur;

  assign sts.has_result = (cmd_r == CMD_RD_COUNT) || (cmd_r == CMD_RST_COUNT) ||
                          (cmd_r == CMD_RD_PERIOD) || (cmd_r == CMD_RD_FREQ) ||
                          (cmd_r == CMD_RD_AGE);
  assign sts.need_div   = (cmd_r == CMD_RD_FREQ) && on && tb_on && in_window &&
                          (lp_cur != 16'd0);
  assign sts.div_done   = div_done;

  mppm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      timebase_ms    <= '0;
      channel_enable <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TIMEBASE: timebase_ms    <= cfg_data;
        CFG_ENABLE:   channel_enable <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_cmd;
      ch_r  <= in_channel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        edge_count[i]     <= '0;
        last_edge_time[i] <= '0;
        last_period[i]    <= '0;
      end
    end else if (ctl.exec) begin
      case (cmd_r)
        CMD_TICK: time_now <= time_now + 16'd1;
        CMD_EDGE: begin
          if (on) begin
            edge_count[idx]     <= cnt_cur + 32'd1;
            last_period[idx]    <= (age_raw == 16'd0) ? 16'd1 : age_raw;
            last_edge_time[idx] <= time_now;
          end
        end
        CMD_RST_COUNT: begin
          if (on) edge_count[idx] <= '0;
        end
        CMD_RD_PERIOD, CMD_RD_FREQ: begin
          if (on && tb_on && stale) last_period[idx] <= PERIOD_INVALID;
        end
        CMD_RD_AGE: begin
          if (on && stale) last_period[idx] <= PERIOD_INVALID;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      status <= (cmd_r == CMD_RST_COUNT) && !on;
      case (cmd_r)
        CMD_RD_COUNT:  value <= on ? cnt_cur : 32'd0;
        CMD_RD_PERIOD: value <= {16'd0, period_rd};
        CMD_RD_AGE:    value <= {16'd0, on ? age_val : PERIOD_INVALID};
        default:       value <= '0;
      endcase
    end else if (div_done) begin
      value <= {(32 - DIV_STEPS)'(0), quotient};
    end
  end

endmodule

`default_nettype wire

// ===== sv/mppm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mppm_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire mppm_pkg::sts_t sts,
  output mppm_pkg::ctl_t ctl
);
  import mppm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: begin
        if (sts.need_div) state_next = S_DIV;
        else if (sts.has_result) state_next = S_OUT;
        else state_next = S_IDLE;
      end
      S_DIV:  if (sts.div_done) state_next = S_OUT;
      S_OUT:  if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    ctl.load      = 1'b0;
    ctl.exec      = 1'b0;
    ctl.div_start = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      S_EXEC: begin
        ctl.exec      = 1'b1;
        ctl.div_start = sts.need_div;
      end
      S_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_EXEC))
    else $error("accepted word not executed");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input open while a result is pending");

  a_div_follows: assert property (@(posedge clk) disable iff (rst)
    ctl.div_start |=> (state == S_DIV))
    else $error("division started outside its wait state");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (state == S_DIV))
    else $error("division finished with no frequency read in flight");

endmodule

`default_nettype wire

// ===== sv/multichannel_pulse_period_meter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// pulse counter and period / frequency meter for up to sixteen channels with
// a private 16-bit millisecond clock. each input word carries a command and a
// channel: tick advances the clock, edge counts a pulse and records its
// period, and the read commands return count, period, age or frequency in
// 100 mHz units as one result word (reset count returns status 1 on a
// disabled channel). the user must write timebase_ms and channel_enable through
// the cfg channel only while the block is idle; the block itself does not
// enforce it. one word is handled at a time: tick and edge pass through
// accept and execute, count, period, age and reset reads also wait in the
// output register until taken, and a frequency read with a valid period adds
// a divide step (without one it does not), in which the restoring divider
// yields one quotient bit of 10000 / period per cycle. all channel state is
// reset at once, so no clearing pass follows reset.
module multichannel_pulse_period_meter_unit #(
  parameter int CHANNELS = 16
) (
  input wire logic   clk,
  input wire logic   rst,
  mppm_in_if.sink    item_in,
  mppm_out_if.source result_out,
  mppm_cfg_if.sink   cfg
);
  import mppm_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // register writes are always taken
  assign cfg.ready = 1'b1;

  // sequencer: accept, execute, divide, present
  mppm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_in.valid),
    .in_ready  (item_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // channel state, config registers, divider and result register
  mppm_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .in_cmd     (item_in.cmd),
    .in_channel (item_in.channel),
    .ctl        (ctl),
    .sts        (sts),
    .value      (result_out.value),
    .status     (result_out.status)
  );

endmodule

`default_nettype wire
